// ----- sv/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types and constants of the two-wire bus master.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int HALF_W     = 8;
   localparam int POLL_W     = 10;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RST    = 8'd6;
   localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 10'd100;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_POLL_LIMIT = 1'd1;

   typedef enum logic [2:0] {
      CMD_RELEASE = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_READ    = 3'd4,
      CMD_GET_ACK = 3'd5,
      CMD_ACK     = 3'd6,
      CMD_NACK    = 3'd7
   } cmd_type;

   typedef enum logic [10:0] {
      PH_IDLE  = 11'b000_0000_0001,
      PH_A     = 11'b000_0000_0010,
      PH_B     = 11'b000_0000_0100,
      PH_WHI   = 11'b000_0000_1000,
      PH_WLO   = 11'b000_0001_0000,
      PH_RPRE  = 11'b000_0010_0000,
      PH_RHI   = 11'b000_0100_0000,
      PH_RLO   = 11'b000_1000_0000,
      PH_GHI   = 11'b001_0000_0000,
      PH_GPOLL = 11'b010_0000_0000,
      PH_GLO   = 11'b100_0000_0000
   } phase_type;

   // one result of a tick
   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 sda_drive;
      logic                 ready_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] read_data;
      logic                 ack_ok;
   } result_type;

endpackage

// ----- sv/i2cbb_engine.sv -----
// ----------------------------------------------------------------------------
// i2cbb_engine
// Bus sequencer state and its single-tick update; presents the result of
// the tick being taken.
// ----------------------------------------------------------------------------
module i2cbb_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            cmd_valid,
   input  logic [2:0]                      req_type,
   input  logic [i2cbb_pkg::BYTE_BITS-1:0] write_data,
   input  logic                            sda_sample,
   input  logic [i2cbb_pkg::HALF_W-1:0]    half_period,
   input  logic [i2cbb_pkg::POLL_W-1:0]    ack_poll_limit,
   output i2cbb_pkg::result_type           result
);
   import i2cbb_pkg::*;

   phase_type            phase_ff, phase_in;
   cmd_type              op_ff, op_in;
   logic [CNT_W-1:0]     bit_ff, bit_in;
   logic [BYTE_BITS-1:0] shift_ff, shift_in;
   logic [HALF_W-1:0]    delay_ff, delay_in;
   logic [POLL_W-1:0]    poll_ff, poll_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 drive_ff, drive_in;
   logic                 ack_ff, ack_in;
   logic [BYTE_BITS-1:0] rd_ff, rd_in;
   logic                 done;
   logic [HALF_W-1:0]    reload;
   logic [POLL_W-1:0]    poll_inc;
   cmd_type              new_op;

   assign reload   = (half_period == '0) ? '0 : half_period - 1'b1;
   assign poll_inc = poll_ff + 1'b1;
   assign new_op   = cmd_type'(req_type);

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drive_in = drive_ff;
      ack_in   = ack_ff;
      rd_in    = rd_ff;
      done     = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (cmd_valid) begin
            op_in    = new_op;
            delay_in = reload;
            unique case (new_op)
               CMD_START: begin
                  phase_in = PH_A; scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b1;
               end
               CMD_STOP: begin
                  phase_in = PH_A; scl_in = 1'b1; sda_in = 1'b0; drive_in = 1'b1;
               end
               CMD_WRITE: begin
                  shift_in = write_data;
                  bit_in   = '0;
                  phase_in = PH_WHI; scl_in = 1'b1;
                  sda_in   = write_data[BYTE_BITS-1]; drive_in = 1'b1;
               end
               CMD_READ: begin
                  shift_in = '0;
                  bit_in   = '0;
                  phase_in = PH_RPRE; scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
               end
               CMD_GET_ACK: begin
                  poll_in  = '0;
                  phase_in = PH_GHI; scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
               end
               CMD_ACK: begin
                  phase_in = PH_A; scl_in = 1'b1; sda_in = 1'b0; drive_in = 1'b1;
               end
               CMD_NACK, CMD_RELEASE: begin
                  phase_in = PH_A; scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b1;
               end
            endcase
         end
      end else if (phase_ff == PH_GPOLL || (delay_ff == '0 && phase_ff == PH_GHI)) begin
         // one acknowledge sample per tick once the clock-high phase is over
         phase_in = PH_GPOLL;
         if (!sda_sample) begin
            ack_in   = 1'b1;
            phase_in = PH_GLO; scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
            delay_in = reload;
         end else begin
            poll_in = poll_inc;
            if (poll_inc >= ack_poll_limit) begin
               ack_in   = 1'b0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
      end else if (delay_ff != '0) begin
         delay_in = delay_ff - 1'b1;
      end else begin
         delay_in = reload;
         unique case (phase_ff)
            PH_A: begin
               phase_in = PH_B; drive_in = 1'b1;
               case (op_ff)
                  CMD_START: begin scl_in = 1'b0; sda_in = 1'b0; end
                  CMD_STOP:  begin scl_in = 1'b1; sda_in = 1'b1; end
                  CMD_ACK:   begin scl_in = 1'b0; sda_in = 1'b0; end
                  CMD_NACK:  begin scl_in = 1'b0; sda_in = 1'b1; end
                  default: begin
                     phase_in = PH_IDLE; drive_in = drive_ff; delay_in = delay_ff;
                     done     = 1'b1;
                  end
               endcase
            end
            PH_WHI: begin
               shift_in = {shift_ff[BYTE_BITS-2:0], 1'b0};
               bit_in   = bit_ff + 1'b1;
               phase_in = PH_WLO; scl_in = 1'b0; drive_in = 1'b1;
            end
            PH_WLO: begin
               if (bit_ff >= CNT_W'(BYTE_BITS)) begin
                  sda_in   = 1'b0;
                  phase_in = PH_IDLE; delay_in = delay_ff;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_WHI; scl_in = 1'b1;
                  sda_in   = shift_ff[BYTE_BITS-1]; drive_in = 1'b1;
               end
            end
            PH_RPRE: begin
               phase_in = PH_RHI; scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
            end
            PH_RHI: begin
               shift_in = {shift_ff[BYTE_BITS-2:0], sda_sample};
               bit_in   = bit_ff + 1'b1;
               phase_in = PH_RLO; scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
            end
            PH_RLO: begin
               if (bit_ff >= CNT_W'(BYTE_BITS)) begin
                  rd_in    = shift_ff;
                  drive_in = 1'b1;
                  phase_in = PH_IDLE; delay_in = delay_ff;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_RHI; scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
               end
            end
            PH_GLO: begin
               drive_in = 1'b1;
               phase_in = PH_IDLE; delay_in = delay_ff;
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE; delay_in = delay_ff;
               done     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= CMD_RELEASE;
         bit_ff   <= '0;
         shift_ff <= '0;
         delay_ff <= '0;
         poll_ff  <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drive_ff <= 1'b1;
         ack_ff   <= 1'b0;
         rd_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         delay_ff <= delay_in;
         poll_ff  <= poll_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drive_ff <= drive_in;
         ack_ff   <= ack_in;
         rd_ff    <= rd_in;
      end
   end

   assign result.scl_level = scl_in;
   assign result.sda_level = sda_in;
   assign result.sda_drive = drive_in;
   assign result.ready_res = (phase_in == PH_IDLE);
   assign result.done_res  = done;
   assign result.read_data = rd_in;
   assign result.ack_ok    = ack_in;

endmodule

// ----- sv/i2c_bitbang_master_top.sv -----
// ----------------------------------------------------------------------------
// i2c_bitbang_master_top
// Two-wire bus master stepped by one tick transfer at a time.
// ----------------------------------------------------------------------------
// Each req_ transfer is one bus time tick: it carries an optional command
// (req_cmd_valid, req_type, req_write_data, taken only while the master is
// idle) and the sampled data-line level. Each tick gives exactly one rsp_
// transfer with the clock/data levels, data-line drive enable, ready and
// done flags, last read byte and last acknowledge result.
// The result of a tick is registered in the output register, or in the skid
// register while a result waits; a tick is accepted every cycle that
// req_ready is high: one tick per clock while rsp_ready keeps up.
// A two-entry output buffer (result register plus skid register) lets one
// more tick be taken while a result waits; req_ready drops only when both
// entries are full, and the sequencer holds its state while it is low.
// Reset returns the sequencer to idle with both lines released high, the
// drive enable set, the half period at 6 and the poll limit at 100.
// csr_ writes take effect at once and must be made only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd_valid,
   input  logic [2:0]                       req_type,
   input  logic [i2cbb_pkg::BYTE_BITS-1:0]  req_write_data,
   input  logic                             req_sda_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_scl_level,
   output logic                             rsp_sda_level,
   output logic                             rsp_sda_drive,
   output logic                             rsp_ready_res,
   output logic                             rsp_done_res,
   output logic [i2cbb_pkg::BYTE_BITS-1:0]  rsp_read_data,
   output logic                             rsp_ack_ok,
   input  logic                             csr_we,
   input  logic [i2cbb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2cbb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import i2cbb_pkg::*;

   logic [HALF_W-1:0] half_ff;
   logic [POLL_W-1:0] limit_ff;
   logic              accept;
   result_type        step_res;
   result_type        out_ff, skid_ff;
   logic              out_valid_ff, skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= HALF_PERIOD_RST;
         limit_ff <= ACK_POLL_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_PERIOD:    half_ff  <= csr_wdata[HALF_W-1:0];
            CSR_ACK_POLL_LIMIT: limit_ff <= csr_wdata[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   i2cbb_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .cmd_valid      (req_cmd_valid),
      .req_type       (req_type),
      .write_data     (req_write_data),
      .sda_sample     (req_sda_in),
      .half_period    (half_ff),
      .ack_poll_limit (limit_ff),
      .result         (step_res)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= step_res;
         end
      end else if (accept) begin
         skid_ff <= step_res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = out_ff.scl_level;
   assign rsp_sda_level = out_ff.sda_level;
   assign rsp_sda_drive = out_ff.sda_drive;
   assign rsp_ready_res = out_ff.ready_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_ack_ok    = out_ff.ack_ok;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted tick left no result in the output register");

   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.done_res) |-> out_ff.ready_res)
      else $error("done flagged while the sequencer is still busy");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-banged two-wire bus master.
// ----------------------------------------------------------------------------
// Every req_ transfer is one bus tick. A tick-accurate model of the sequencer
// runs beside the block and queues the expected line levels and flags of
// each tick; every rsp_ transfer is checked against the oldest entry.
// Commands are issued as whole bus operations: one command tick, then
// ticks until the model returns to idle, with the slave's data-line levels
// shaped so that reads return chosen bytes and acknowledge polls succeed
// early, on the last allowed sample or time out. Both channels idle at
// random; configuration is changed only with the master idle and drained.
// ----------------------------------------------------------------------------
module testbench;
   import i2cbb_pkg::*;

   localparam int unsigned TICK_LIMIT = 2_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd_valid;
   logic [2:0]            req_type;
   logic [BYTE_BITS-1:0]  req_write_data;
   logic                  req_sda_in;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_scl_level;
   logic                  rsp_sda_level;
   logic                  rsp_sda_drive;
   logic                  rsp_ready_res;
   logic                  rsp_done_res;
   logic [BYTE_BITS-1:0]  rsp_read_data;
   logic                  rsp_ack_ok;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   i2c_bitbang_master_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd_valid  (req_cmd_valid),
      .req_type       (req_type),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_ok     (rsp_ack_ok),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // sequencer model state
   logic [HALF_W-1:0]    m_half  = HALF_PERIOD_RST;
   logic [POLL_W-1:0]    m_limit = ACK_POLL_LIMIT_RST;
   phase_type            m_ph    = PH_IDLE;
   cmd_type              m_act   = CMD_RELEASE;
   logic [CNT_W-1:0]     m_bits  = '0;
   logic [BYTE_BITS-1:0] m_shreg = '0;
   logic [HALF_W-1:0]    m_dly   = '0;
   logic [POLL_W-1:0]    m_polls = '0;
   logic                 m_scl   = 1'b1;
   logic                 m_sda   = 1'b1;
   logic                 m_drv   = 1'b1;
   logic                 m_ackf  = 1'b0;
   logic [BYTE_BITS-1:0] m_rdbyte = '0;
   logic                 m_done  = 1'b0;

   result_type bus_levels_q[$];

   int unsigned cycles;
   int unsigned mismatches;
   int unsigned n_ticks;
   int unsigned n_cmds;
   int unsigned n_timeouts;
   int unsigned n_acks;
   int unsigned n_csr;
   int unsigned hold_cycles;
   bit          calm_req;
   bit          calm_rsp;

   // ------------------------------------------------------------------------
   // model of one tick
   // ------------------------------------------------------------------------
   function automatic void enter_phase(input phase_type p, input logic c,
                                       input logic d, input logic e);
      m_ph  = p;
      m_scl = c;
      m_sda = d;
      m_drv = e;
      m_dly = (m_half == '0) ? '0 : m_half - 1'b1;
   endfunction

   function automatic void finish_cmd();
      m_ph   = PH_IDLE;
      m_done = 1'b1;
   endfunction

   function automatic void poll_sample(input logic s);
      if (!s) begin
         m_ackf = 1'b1;
         n_acks++;
         enter_phase(PH_GLO, 1'b0, 1'b1, 1'b0);
      end else begin
         m_polls = m_polls + 1'b1;
         if (m_polls >= m_limit) begin
            m_ackf = 1'b0;
            n_timeouts++;
            finish_cmd();
         end
      end
   endfunction

   function automatic void end_phase(input logic s);
      case (m_ph)
         PH_A: begin
            case (m_act)
               CMD_START, CMD_ACK: enter_phase(PH_B, 1'b0, 1'b0, 1'b1);
               CMD_STOP:           enter_phase(PH_B, 1'b1, 1'b1, 1'b1);
               CMD_NACK:           enter_phase(PH_B, 1'b0, 1'b1, 1'b1);
               default:            finish_cmd();
            endcase
         end
         PH_WHI: begin
            m_shreg = {m_shreg[BYTE_BITS-2:0], 1'b0};
            m_bits  = m_bits + 1'b1;
            enter_phase(PH_WLO, 1'b0, m_sda, 1'b1);
         end
         PH_WLO: begin
            if (m_bits >= BYTE_BITS) begin
               m_sda = 1'b0;
               finish_cmd();
            end else begin
               enter_phase(PH_WHI, 1'b1, m_shreg[BYTE_BITS-1], 1'b1);
            end
         end
         PH_RPRE: enter_phase(PH_RHI, 1'b1, 1'b1, 1'b0);
         PH_RHI: begin
            m_shreg = {m_shreg[BYTE_BITS-2:0], s};
            m_bits  = m_bits + 1'b1;
            enter_phase(PH_RLO, 1'b0, 1'b1, 1'b0);
         end
         PH_RLO: begin
            if (m_bits >= BYTE_BITS) begin
               m_rdbyte = m_shreg;
               m_drv    = 1'b1;
               finish_cmd();
            end else begin
               enter_phase(PH_RHI, 1'b1, 1'b1, 1'b0);
            end
         end
         PH_GHI: begin
            m_ph = PH_GPOLL;
            poll_sample(s);
         end
         PH_GLO: begin
            m_drv = 1'b1;
            finish_cmd();
         end
         default: finish_cmd();
      endcase
   endfunction

   function automatic void start_cmd(input cmd_type op, input logic [BYTE_BITS-1:0] wd);
      m_act = op;
      case (op)
         CMD_STOP, CMD_ACK: enter_phase(PH_A, 1'b1, 1'b0, 1'b1);
         CMD_WRITE: begin
            m_shreg = wd;
            m_bits  = '0;
            enter_phase(PH_WHI, 1'b1, wd[BYTE_BITS-1], 1'b1);
         end
         CMD_READ: begin
            m_shreg = '0;
            m_bits  = '0;
            enter_phase(PH_RPRE, 1'b0, 1'b1, 1'b0);
         end
         CMD_GET_ACK: begin
            m_polls = '0;
            enter_phase(PH_GHI, 1'b1, 1'b1, 1'b0);
         end
         default: enter_phase(PH_A, 1'b1, 1'b1, 1'b1);
      endcase
   endfunction

   function automatic void predict_bus_tick(input logic cv, input cmd_type t,
                                            input logic [BYTE_BITS-1:0] wd,
                                            input logic s);
      result_type want;
      m_done = 1'b0;
      if (m_ph == PH_IDLE) begin
         if (cv) start_cmd(t, wd);
      end else if (m_ph == PH_GPOLL) begin
         poll_sample(s);
      end else if (m_dly != '0) begin
         m_dly = m_dly - 1'b1;
      end else begin
         end_phase(s);
      end
      want.scl_level = m_scl;
      want.sda_level = m_sda;
      want.sda_drive = m_drv;
      want.ready_res = (m_ph == PH_IDLE);
      want.done_res  = m_done;
      want.read_data = m_rdbyte;
      want.ack_ok    = m_ackf;
      bus_levels_q.push_back(want);
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic send_tick(input logic cv, input cmd_type t,
                            input logic [BYTE_BITS-1:0] wd, input logic s);
      int unsigned gap;
      gap = calm_req ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd_valid  <= cv;
      req_type       <= t;
      req_write_data <= wd;
      req_sda_in     <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_ticks++;
      predict_bus_tick(cv, t, wd, s);
   endtask

   // one bus operation from its command tick until the master is idle again;
   // the slave shifts out rd_byte and acknowledges after ack_after high polls
   task automatic issue_cmd(input cmd_type op, input logic [BYTE_BITS-1:0] wd,
                            input logic [BYTE_BITS-1:0] rd_byte,
                            input int unsigned ack_after);
      int unsigned n_high;
      logic s;
      n_high = 0;
      repeat ($urandom_range(0, 2))
         send_tick(1'b0, cmd_type'(3'($urandom_range(0, 7))),
                   BYTE_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_tick(1'b1, op, wd, 1'($urandom_range(0, 1)));
      n_cmds++;
      while (m_ph != PH_IDLE) begin
         if (m_ph == PH_RHI) begin
            s = rd_byte[3'd7 - m_bits[2:0]];
         end else if (m_ph == PH_GPOLL || (m_ph == PH_GHI && m_dly == '0)) begin
            s = (n_high >= ack_after) ? 1'b0 : 1'b1;
            n_high++;
         end else begin
            s = 1'($urandom_range(0, 1));
         end
         // stray commands while busy must be ignored
         send_tick($urandom_range(0, 7) == 0, cmd_type'(3'($urandom_range(0, 7))),
                   BYTE_BITS'($urandom_range(0, 255)), s);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (bus_levels_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HALF_PERIOD) m_half = val[HALF_W-1:0];
      else m_limit = val[POLL_W-1:0];
      n_csr++;
   endtask

   task automatic set_bus(input logic [HALF_W-1:0] half, input logic [POLL_W-1:0] lim);
      logic [CSR_DATA_W-HALF_W-1:0] junk;
      junk = (CSR_DATA_W-HALF_W)'($urandom_range(0, 3));
      write_csr(CSR_HALF_PERIOD, {junk, half});
      write_csr(CSR_ACK_POLL_LIMIT, lim);
   endtask

   task automatic random_cmd();
      int unsigned r;
      int unsigned ack_after;
      r = $urandom_range(0, 99);
      if (r < 55) ack_after = $urandom_range(0, 3);
      else if (r < 85) ack_after = int'(m_limit) - 1 + int'($urandom_range(0, 2));
      else ack_after = 4096;
      issue_cmd(cmd_type'(3'($urandom_range(0, 7))), BYTE_BITS'($urandom_range(0, 255)),
                BYTE_BITS'($urandom_range(0, 255)), ack_after);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_defaults();
      // one release and one start with the reset timing
      issue_cmd(CMD_RELEASE, 8'h00, 8'h00, 0);
      issue_cmd(CMD_START, 8'h00, 8'h00, 0);
   endtask

   task automatic test_every_command();
      set_bus(8'd1, 10'd4);
      issue_cmd(CMD_RELEASE, 8'h00, 8'h00, 0);
      issue_cmd(CMD_START, 8'h00, 8'h00, 0);
      issue_cmd(CMD_WRITE, 8'hFF, 8'h00, 0);
      issue_cmd(CMD_WRITE, 8'hA5, 8'h00, 0);
      issue_cmd(CMD_GET_ACK, 8'h00, 8'h00, 0);
      issue_cmd(CMD_GET_ACK, 8'h00, 8'h00, 3);
      issue_cmd(CMD_GET_ACK, 8'h00, 8'h00, 4);
      issue_cmd(CMD_READ, 8'h00, 8'hFF, 0);
      issue_cmd(CMD_READ, 8'h00, 8'h5A, 0);
      issue_cmd(CMD_ACK, 8'h00, 8'h00, 0);
      issue_cmd(CMD_NACK, 8'h00, 8'h00, 0);
      issue_cmd(CMD_STOP, 8'h00, 8'h00, 0);
   endtask

   task automatic test_timing_extremes();
      // longest level phase
      set_bus(8'd255, 10'd1023);
      issue_cmd(CMD_RELEASE, 8'h00, 8'h00, 0);
      // zero half period behaves as one tick, zero limit fails on first high
      set_bus(8'd0, 10'd0);
      issue_cmd(CMD_WRITE, 8'hC3, 8'h00, 0);
      issue_cmd(CMD_GET_ACK, 8'h00, 8'h00, 4096);
      issue_cmd(CMD_GET_ACK, 8'h00, 8'h00, 0);
      issue_cmd(CMD_READ, 8'h00, 8'h96, 0);
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_bus(8'd1, 10'd1);
            1: set_bus(8'd2, 10'd3);
            default: set_bus(HALF_W'($urandom_range(1, 3)), POLL_W'($urandom_range(1, 8)));
         endcase
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         repeat (3) random_cmd();
      end
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_cycles != 0) hold_cycles--;
      else if (!calm_rsp) hold_cycles = pick_gap();
      rsp_ready <= (hold_cycles == 0);
   end

   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.scl_level = rsp_scl_level;
         got.sda_level = rsp_sda_level;
         got.sda_drive = rsp_sda_drive;
         got.ready_res = rsp_ready_res;
         got.done_res  = rsp_done_res;
         got.read_data = rsp_read_data;
         got.ack_ok    = rsp_ack_ok;
         if (bus_levels_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer at cycle %0d: %p", cycles, got);
         end else begin
            want = bus_levels_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch at cycle %0d (exp/got): scl %b/%b sda %b/%b ",
                            "drv %b/%b rdy %b/%b done %b/%b rd %h/%h ack %b/%b"},
                           cycles, want.scl_level, got.scl_level,
                           want.sda_level, got.sda_level, want.sda_drive, got.sda_drive,
                           want.ready_res, got.ready_res, want.done_res, got.done_res,
                           want.read_data, got.read_data, want.ack_ok, got.ack_ok);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == TICK_LIMIT) begin
         $display("[i2c_bitbang_master_top] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd_valid  <= 1'b0;
      req_type       <= CMD_RELEASE;
      req_write_data <= '0;
      req_sda_in     <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_HALF_PERIOD;
      csr_wdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_every_command();
      test_timing_extremes();
      test_random_traffic();

      // drain, then allow the output buffer to settle
      req_valid <= 1'b0;
      calm_rsp = 1'b0;
      while (bus_levels_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (bus_levels_q.size() != 0) mismatches++;

      $display("ran %0d ticks: %0d bus commands, %0d register writes",
               n_ticks, n_cmds, n_csr);
      $display("saw %0d slave acknowledges and %0d poll timeouts, %0d mismatches",
               n_acks, n_timeouts, mismatches);
      if (mismatches == 0) begin
         $display("[i2c_bitbang_master_top] OK");
      end else begin
         $display("[i2c_bitbang_master_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/i2cbb_pkg.sv
sv/i2cbb_engine.sv
sv/i2c_bitbang_master_top.sv
dv/testbench.sv
